>>> hdl/pndm_pkg.sv
// ----------------------------------------------------------------------------
// pndm_pkg
// Shared types and constants for the pedal noise and drift monitor.
// ----------------------------------------------------------------------------
package pndm_pkg;

    typedef struct packed {
        logic        mode;
        logic [9:0]  raw_gas;
        logic [9:0]  raw_clutch;
        logic [31:0] now_ms;
    } in_t;

    typedef struct packed {
        logic       clutch_alert;
        logic       gas_alert;
        logic [6:0] gas_percent;
    } out_t;

    typedef struct packed {
        logic [2:0]  enables;
        logic [9:0]  gas_idle_max;
        logic [9:0]  gas_full_min;
        logic [9:0]  clutch_margin;
        logic [7:0]  clutch_repeat;
        logic [31:0] window_ms;
        logic [31:0] timeout_ms;
        logic [31:0] cooldown_ms;
    } cfg_t;

    localparam int PADDR_W = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_ENABLES       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAS_IDLE_MAX  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAS_FULL_MIN  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CLUTCH_MARGIN = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CLUTCH_REPEAT = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_MS     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_MS    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_COOLDOWN_MS   = 3'd7;

    localparam logic [2:0]  RST_ENABLES       = 3'd7;
    localparam logic [9:0]  RST_GAS_IDLE_MAX  = 10'd51;
    localparam logic [9:0]  RST_GAS_FULL_MIN  = 10'd951;
    localparam logic [9:0]  RST_CLUTCH_MARGIN = 10'd51;
    localparam logic [7:0]  RST_CLUTCH_REPEAT = 8'd4;
    localparam logic [31:0] RST_WINDOW_MS     = 32'd30000;
    localparam logic [31:0] RST_TIMEOUT_MS    = 32'd10000;
    localparam logic [31:0] RST_COOLDOWN_MS   = 32'd60000;

    localparam int EN_MIRROR = 0;
    localparam int EN_CLUTCH = 1;
    localparam int EN_GAS    = 2;

    localparam logic MODE_SAMPLE    = 1'b0;
    localparam logic MODE_RECONNECT = 1'b1;

    localparam int unsigned MIN_USAGE_PCT = 20;
    localparam int unsigned PCT_SCALE     = 100;

endpackage

>>> hdl/pedal_noise_and_drift_monitor.sv
// ----------------------------------------------------------------------------
// pedal_noise_and_drift_monitor
// Watches pedal samples for a stuck clutch and for gas travel drift.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one item per sample (or a reconnect marker) with valid/ready.
//   m_* returns exactly one result item per input item, in order.
//   The APB port holds eight 32-bit registers at byte offsets 0x00..0x1C;
//   pready is tied high, so each write takes its setup and access cycles.
// Path: an accepted item waits in the input register; its result is loaded
//   into the result register once that is free or being read, and m_valid rises.
// Throughput: one item per cycle while m_ready stays high; the input register
//   refills while a finished result waits in the result register.
// Stall: with m_ready low the result holds; one more item is taken into
//   the input register, after which s_ready drops until m_ready returns.
// Reset: synchronous, active-low aresetn clears the valid flags of both pipeline
//   registers, the monitor state and restores the register defaults.
// ----------------------------------------------------------------------------
module pedal_noise_and_drift_monitor #(
    parameter int unsigned TRAVEL_MAX = 1023
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  pndm_pkg::in_t                 s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output pndm_pkg::out_t                m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pndm_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import pndm_pkg::*;

    cfg_t cfg;
    in_t  in_data_reg;
    logic in_valid_reg;
    out_t out_data_reg;
    logic out_valid_reg;
    out_t result;
    logic advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    pndm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pndm_core #(
        .TRAVEL_MAX (TRAVEL_MAX)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step_en (advance),
        .item    (in_data_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

endmodule

>>> hdl/pndm_regs.sv
// ----------------------------------------------------------------------------
// pndm_regs
// APB configuration registers: thresholds, timing windows and check enables.
// ----------------------------------------------------------------------------
module pndm_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pndm_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output pndm_pkg::cfg_t                cfg
);
    import pndm_pkg::*;

    cfg_t                 cfg_reg;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx    = paddr[PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enables       <= RST_ENABLES;
            cfg_reg.gas_idle_max  <= RST_GAS_IDLE_MAX;
            cfg_reg.gas_full_min  <= RST_GAS_FULL_MIN;
            cfg_reg.clutch_margin <= RST_CLUTCH_MARGIN;
            cfg_reg.clutch_repeat <= RST_CLUTCH_REPEAT;
            cfg_reg.window_ms     <= RST_WINDOW_MS;
            cfg_reg.timeout_ms    <= RST_TIMEOUT_MS;
            cfg_reg.cooldown_ms   <= RST_COOLDOWN_MS;
        end else if (wr_en) begin
            unique case (idx)
                REG_ENABLES:       cfg_reg.enables       <= pwdata[2:0];
                REG_GAS_IDLE_MAX:  cfg_reg.gas_idle_max  <= pwdata[9:0];
                REG_GAS_FULL_MIN:  cfg_reg.gas_full_min  <= pwdata[9:0];
                REG_CLUTCH_MARGIN: cfg_reg.clutch_margin <= pwdata[9:0];
                REG_CLUTCH_REPEAT: cfg_reg.clutch_repeat <= pwdata[7:0];
                REG_WINDOW_MS:     cfg_reg.window_ms     <= pwdata;
                REG_TIMEOUT_MS:    cfg_reg.timeout_ms    <= pwdata;
                REG_COOLDOWN_MS:   cfg_reg.cooldown_ms   <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_ENABLES:       prdata = 32'(cfg_reg.enables);
            REG_GAS_IDLE_MAX:  prdata = 32'(cfg_reg.gas_idle_max);
            REG_GAS_FULL_MIN:  prdata = 32'(cfg_reg.gas_full_min);
            REG_CLUTCH_MARGIN: prdata = 32'(cfg_reg.clutch_margin);
            REG_CLUTCH_REPEAT: prdata = 32'(cfg_reg.clutch_repeat);
            REG_WINDOW_MS:     prdata = cfg_reg.window_ms;
            REG_TIMEOUT_MS:    prdata = cfg_reg.timeout_ms;
            REG_COOLDOWN_MS:   prdata = cfg_reg.cooldown_ms;
        endcase
    end

endmodule

>>> hdl/pndm_core.sv
// ----------------------------------------------------------------------------
// pndm_core
// Clutch stuck check and gas drift check: monitor state and per-item result.
// ----------------------------------------------------------------------------
module pndm_core #(
    parameter int unsigned TRAVEL_MAX = 1023
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  pndm_pkg::cfg_t cfg,
    input  logic           step_en,
    input  pndm_pkg::in_t  item,
    output pndm_pkg::out_t result
);
    import pndm_pkg::*;

    localparam int TW = $clog2(TRAVEL_MAX + 1);
    localparam int CW = (TW > 10) ? TW : 10;
    // peak * 100 / TRAVEL_MAX as one multiply by a scaled reciprocal
    localparam int NW = $clog2(PCT_SCALE * TRAVEL_MAX + 1);
    localparam int LW = $clog2(TRAVEL_MAX);
    localparam int SH = NW + LW;
    localparam longint unsigned RECIP =
        ((longint'(1) << SH) + longint'(TRAVEL_MAX) - 1) / longint'(TRAVEL_MAX);
    localparam longint unsigned KMUL = longint'(PCT_SCALE) * RECIP;
    localparam int KW = $clog2(KMUL + 1);
    localparam int PW = TW + KW;
    localparam logic [KW-1:0] KMUL_V = KW'(KMUL);

    logic [TW-1:0] prev_clutch_reg,   prev_clutch_next;
    logic [7:0]    stuck_count_reg,   stuck_count_next;
    logic          racing_reg,        racing_next;
    logic [TW-1:0] peak_gas_reg,      peak_gas_next;
    logic [31:0]   full_time_reg,     full_time_next;
    logic [31:0]   activity_time_reg, activity_time_next;
    logic [31:0]   alert_time_reg,    alert_time_next;

    logic [TW-1:0] gas, clutch, diff, peak_base, peak_max;
    logic [7:0]    stuck_mid;
    logic          gas_idle, stuck_hit, clutch_fire;
    logic          restart, idle_expire, racing_new, at_full, window_due;
    logic          usage_ok, gas_fire;
    logic [31:0]   full_base;
    logic [PW-1:0] prod, pct_q;

    function automatic logic [TW-1:0] to_travel(input logic [9:0] raw, input logic mirror);
        logic [CW-1:0] raw_w;
        logic [TW-1:0] sat;
        raw_w = CW'(raw);
        if (raw_w > CW'(TRAVEL_MAX)) begin
            sat = TW'(TRAVEL_MAX);
        end else begin
            sat = TW'(raw);
        end
        return mirror ? TW'(TRAVEL_MAX) - sat : sat;
    endfunction

    always_comb begin
        gas    = to_travel(item.raw_gas, cfg.enables[EN_MIRROR]);
        clutch = to_travel(item.raw_clutch, cfg.enables[EN_MIRROR]);

        // clutch stuck detection
        gas_idle  = CW'(gas) <= CW'(cfg.gas_idle_max);
        diff      = (clutch >= prev_clutch_reg) ? clutch - prev_clutch_reg
                                                : prev_clutch_reg - clutch;
        stuck_hit = gas_idle && (clutch != '0) && (CW'(diff) <= CW'(cfg.clutch_margin));
        if (!stuck_hit) begin
            stuck_mid = '0;
        end else if (stuck_count_reg == 8'hFF) begin
            stuck_mid = stuck_count_reg;
        end else begin
            stuck_mid = stuck_count_reg + 8'd1;
        end
        clutch_fire = stuck_mid >= cfg.clutch_repeat;

        // gas drift detection
        restart     = !gas_idle && !racing_reg;
        idle_expire = racing_reg && ((item.now_ms - activity_time_reg) > cfg.timeout_ms);
        racing_new  = !gas_idle || (racing_reg && !idle_expire);
        full_base   = restart ? item.now_ms : full_time_reg;
        peak_base   = restart ? '0 : peak_gas_reg;
        peak_max    = (gas > peak_base) ? gas : peak_base;
        at_full     = CW'(gas) >= CW'(cfg.gas_full_min);
        window_due  = ((item.now_ms - full_base) > cfg.window_ms)
                   && ((item.now_ms - alert_time_reg) > cfg.cooldown_ms);
        prod        = PW'(peak_max) * KMUL_V;
        pct_q       = prod >> SH;
        usage_ok    = pct_q > PW'(MIN_USAGE_PCT);
        gas_fire    = racing_new && !at_full && window_due && usage_ok;
    end

    always_comb begin
        prev_clutch_next   = prev_clutch_reg;
        stuck_count_next   = stuck_count_reg;
        racing_next        = racing_reg;
        peak_gas_next      = peak_gas_reg;
        full_time_next     = full_time_reg;
        activity_time_next = activity_time_reg;
        alert_time_next    = alert_time_reg;
        result             = '0;

        if (item.mode == MODE_RECONNECT) begin
            prev_clutch_next   = '0;
            stuck_count_next   = '0;
            racing_next        = 1'b0;
            peak_gas_next      = '0;
            full_time_next     = item.now_ms;
            activity_time_next = item.now_ms;
        end else begin
            if (cfg.enables[EN_CLUTCH]) begin
                prev_clutch_next    = clutch;
                stuck_count_next    = clutch_fire ? 8'd0 : stuck_mid;
                result.clutch_alert = clutch_fire;
            end
            if (cfg.enables[EN_GAS]) begin
                racing_next    = racing_new;
                full_time_next = full_base;
                peak_gas_next  = peak_base;
                if (!gas_idle) begin
                    activity_time_next = item.now_ms;
                end
                if (racing_new) begin
                    if (at_full) begin
                        peak_gas_next  = '0;
                        full_time_next = item.now_ms;
                    end else begin
                        peak_gas_next = peak_max;
                    end
                end
                if (gas_fire) begin
                    alert_time_next    = item.now_ms;
                    result.gas_alert   = 1'b1;
                    result.gas_percent = pct_q[6:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_clutch_reg   <= '0;
            stuck_count_reg   <= '0;
            racing_reg        <= 1'b0;
            peak_gas_reg      <= '0;
            full_time_reg     <= '0;
            activity_time_reg <= '0;
            alert_time_reg    <= '0;
        end else if (step_en) begin
            prev_clutch_reg   <= prev_clutch_next;
            stuck_count_reg   <= stuck_count_next;
            racing_reg        <= racing_next;
            peak_gas_reg      <= peak_gas_next;
            full_time_reg     <= full_time_next;
            activity_time_reg <= activity_time_next;
            alert_time_reg    <= alert_time_next;
        end
    end

endmodule

>>> verif/pedal_noise_and_drift_monitor_test.sv
// ----------------------------------------------------------------------------
// pedal_noise_and_drift_monitor_test
// Self-checking bench for the pedal noise and drift monitor. A queue-fed
// driver pushes pedal samples and reconnect items through the valid/ready
// input. A monitor compares every result item with a cycle-free model of the
// clutch and gas checks. The run walks through several register settings,
// extremes included, under changing sender and receiver idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pedal_noise_and_drift_monitor_test;
    import pndm_pkg::*;

    localparam logic [9:0] AXIS_TOP = 10'd1023;
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    in_t pending_samples[$];
    out_t expected_alerts[$];
    out_t want_item;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // register copy and monitor state as seen by the model
    cfg_t cfg;
    logic [9:0] last_clutch = '0;
    logic [7:0] hold_count = '0;
    logic in_race = 1'b0;
    logic [9:0] gas_peak = '0;
    logic [31:0] full_stamp = '0;
    logic [31:0] active_stamp = '0;
    logic [31:0] alert_stamp = '0;

    // stimulus shaping
    logic [31:0] clock_ms = '0;
    int unsigned scene = 0;
    int hold_level = 0;

    pedal_noise_and_drift_monitor #(
        .TRAVEL_MAX(AXIS_TOP)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [9:0] to_travel(input logic [9:0] raw);
        return cfg.enables[EN_MIRROR] ? AXIS_TOP - raw : raw;
    endfunction

    function automatic out_t monitor_step(input in_t it);
        out_t res;
        logic [9:0] gas;
        logic [9:0] clutch;
        logic [9:0] gap;
        logic [31:0] now;
        logic [31:0] idle_for;
        logic [31:0] since_full;
        logic [31:0] since_alert;
        int unsigned pct;
        res = '0;
        now = it.now_ms;
        if (it.mode == MODE_RECONNECT) begin
            full_stamp = now;
            active_stamp = now;
            in_race = 1'b0;
            gas_peak = '0;
            last_clutch = '0;
            hold_count = '0;
            return res;
        end
        gas = to_travel(it.raw_gas);
        clutch = to_travel(it.raw_clutch);

        if (cfg.enables[EN_CLUTCH]) begin
            gap = (clutch >= last_clutch) ? clutch - last_clutch : last_clutch - clutch;
            if (gas <= cfg.gas_idle_max && clutch != 0 && gap <= cfg.clutch_margin) begin
                if (hold_count != 8'hFF) hold_count = hold_count + 1'b1;
            end else begin
                hold_count = '0;
            end
            last_clutch = clutch;
            if (hold_count >= cfg.clutch_repeat) begin
                res.clutch_alert = 1'b1;
                hold_count = '0;
            end
        end

        if (cfg.enables[EN_GAS]) begin
            idle_for = now - active_stamp;
            if (gas > cfg.gas_idle_max) begin
                if (!in_race) begin
                    full_stamp = now;
                    gas_peak = '0;
                end
                in_race = 1'b1;
                active_stamp = now;
            end else if (in_race && idle_for > cfg.timeout_ms) begin
                in_race = 1'b0;
            end
            if (in_race) begin
                if (gas > gas_peak) gas_peak = gas;
                since_full = now - full_stamp;
                since_alert = now - alert_stamp;
                if (gas >= cfg.gas_full_min) begin
                    full_stamp = now;
                    gas_peak = '0;
                end else if (since_full > cfg.window_ms && since_alert > cfg.cooldown_ms) begin
                    pct = (gas_peak * PCT_SCALE) / AXIS_TOP;
                    if (pct > MIN_USAGE_PCT) begin
                        res.gas_alert = 1'b1;
                        res.gas_percent = pct[6:0];
                        alert_stamp = now;
                    end
                end
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_alerts.push_back(monitor_step(s_data));
            end
            if (!s_valid || s_ready) begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data <= pending_samples.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_alerts.size() == 0) begin
                    $error("result item with nothing expected: %0h", m_data);
                    error_count++;
                end else begin
                    want_item = expected_alerts.pop_front();
                    if (m_data.clutch_alert !== want_item.clutch_alert) begin
                        $error("clutch_alert: expected %0d, got %0d",
                               want_item.clutch_alert, m_data.clutch_alert);
                        error_count++;
                    end
                    if (m_data.gas_alert !== want_item.gas_alert) begin
                        $error("gas_alert: expected %0d, got %0d",
                               want_item.gas_alert, m_data.gas_alert);
                        error_count++;
                    end
                    if (m_data.gas_percent !== want_item.gas_percent) begin
                        $error("gas_percent: expected %0d, got %0d",
                               want_item.gas_percent, m_data.gas_percent);
                        error_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ENABLES:       cfg.enables = value[2:0];
            REG_GAS_IDLE_MAX:  cfg.gas_idle_max = value[9:0];
            REG_GAS_FULL_MIN:  cfg.gas_full_min = value[9:0];
            REG_CLUTCH_MARGIN: cfg.clutch_margin = value[9:0];
            REG_CLUTCH_REPEAT: cfg.clutch_repeat = value[7:0];
            REG_WINDOW_MS:     cfg.window_ms = value;
            REG_TIMEOUT_MS:    cfg.timeout_ms = value;
            default:           cfg.cooldown_ms = value;
        endcase
    endtask

    task automatic write_all(input logic [2:0] en, input logic [9:0] idle,
                             input logic [9:0] full, input logic [9:0] margin,
                             input logic [7:0] rep, input logic [31:0] win,
                             input logic [31:0] tmo, input logic [31:0] cool);
        cfg_write(REG_ENABLES, {29'd0, en});
        cfg_write(REG_GAS_IDLE_MAX, {22'd0, idle});
        cfg_write(REG_GAS_FULL_MIN, {22'd0, full});
        cfg_write(REG_CLUTCH_MARGIN, {22'd0, margin});
        cfg_write(REG_CLUTCH_REPEAT, {24'd0, rep});
        cfg_write(REG_WINDOW_MS, win);
        cfg_write(REG_TIMEOUT_MS, tmo);
        cfg_write(REG_COOLDOWN_MS, cool);
    endtask

    task automatic queue_raw(input logic mode, input logic [9:0] gas, input logic [9:0] clutch,
                             input logic [31:0] now);
        in_t item;
        item.mode = mode;
        item.raw_gas = gas;
        item.raw_clutch = clutch;
        item.now_ms = now;
        pending_samples.push_back(item);
    endtask

    function automatic logic [9:0] pick(input int lo, input int hi);
        if (lo > AXIS_TOP) lo = AXIS_TOP;
        if (hi < 0) hi = 0;
        return 10'($urandom_range(hi, lo));
    endfunction

    task automatic queue_random(input int unsigned count, input int unsigned step_max);
        in_t item;
        int unsigned roll;
        int idle;
        int full;
        int span;
        int jitter;
        logic [9:0] gas;
        logic [9:0] clutch;
        idle = int'(cfg.gas_idle_max);
        full = int'(cfg.gas_full_min);
        span = int'(cfg.clutch_margin);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 12) begin
                scene = $urandom_range(9);
                hold_level = ($urandom_range(7) == 0) ? 0 : $urandom_range(AXIS_TOP, 1);
            end
            roll = $urandom_range(99);
            clock_ms = clock_ms + $urandom_range(step_max);
            item.mode = MODE_SAMPLE;
            item.raw_gas = 10'($urandom);
            item.raw_clutch = 10'($urandom);
            if (roll < 3) begin
                item.mode = MODE_RECONNECT;
            end else if (roll < 8) begin
                clock_ms = $urandom;
            end else begin
                clutch = 10'($urandom);
                if (scene <= 2) begin
                    // gas at rest, clutch wandering around a held position
                    gas = pick(0, idle);
                    if (hold_level != 0) begin
                        jitter = $urandom_range(2 * span + 2);
                        hold_level = hold_level + jitter - span - 1;
                        if (hold_level < 1) hold_level = 1;
                        if (hold_level > AXIS_TOP) hold_level = AXIS_TOP;
                    end
                    clutch = 10'(hold_level);
                end else if (scene <= 7) begin
                    gas = pick(idle + 1, full - 1);
                end else if (scene == 8) begin
                    gas = pick(full, AXIS_TOP);
                end else begin
                    gas = pick(0, idle);
                end
                item.raw_gas = cfg.enables[EN_MIRROR] ? AXIS_TOP - gas : gas;
                item.raw_clutch = cfg.enables[EN_MIRROR] ? AXIS_TOP - clutch : clutch;
            end
            item.now_ms = clock_ms;
            pending_samples.push_back(item);
        end
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_samples.size() != 0 || s_valid || expected_alerts.size() != 0);
    endtask

    task automatic run_phase(input int unsigned idling, input int unsigned count,
                             input int unsigned step_max);
        case (idling)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
        endcase
        queue_random(count, step_max);
        wait_drained();
    endtask

    initial begin
        cfg.enables = RST_ENABLES;
        cfg.gas_idle_max = RST_GAS_IDLE_MAX;
        cfg.gas_full_min = RST_GAS_FULL_MIN;
        cfg.clutch_margin = RST_CLUTCH_MARGIN;
        cfg.clutch_repeat = RST_CLUTCH_REPEAT;
        cfg.window_ms = RST_WINDOW_MS;
        cfg.timeout_ms = RST_TIMEOUT_MS;
        cfg.cooldown_ms = RST_COOLDOWN_MS;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed items on reset settings (axes mirrored)
        queue_raw(MODE_SAMPLE, 10'd0, 10'd0, 32'd0);
        queue_raw(MODE_SAMPLE, AXIS_TOP, AXIS_TOP, 32'd1);
        queue_raw(MODE_RECONNECT, AXIS_TOP, AXIS_TOP, 32'hFFFF_FFFF);
        queue_raw(MODE_RECONNECT, 10'd0, 10'd0, 32'd0);
        // clutch held still with gas at rest, then a change of exactly the margin
        for (int k = 0; k < 5; k++) queue_raw(MODE_SAMPLE, 10'd1000, 10'd600, 32'd10 + k);
        queue_raw(MODE_SAMPLE, 10'd1000, 10'd651, 32'd20);
        queue_raw(MODE_SAMPLE, 10'd1000, 10'd0, 32'd21);
        // partial throttle held past the window and the cooldown
        queue_raw(MODE_RECONNECT, 10'd0, 10'd0, 32'd1000);
        queue_raw(MODE_SAMPLE, 10'd523, 10'd1023, 32'd2000);
        queue_raw(MODE_SAMPLE, 10'd523, 10'd1023, 32'd20000);
        queue_raw(MODE_SAMPLE, 10'd523, 10'd1023, 32'd32001);
        queue_raw(MODE_SAMPLE, 10'd523, 10'd1023, 32'd62001);
        queue_raw(MODE_SAMPLE, 10'd523, 10'd1023, 32'd62002);
        queue_raw(MODE_SAMPLE, 10'd50, 10'd1023, 32'd62003);
        // low peak stays under the usage floor, then the idle timeout
        queue_raw(MODE_SAMPLE, 10'd873, 10'd1023, 32'd200000);
        queue_raw(MODE_SAMPLE, 10'd873, 10'd1023, 32'd300000);
        queue_raw(MODE_SAMPLE, AXIS_TOP, 10'd1023, 32'd320000);
        // timestamps across the wrap
        queue_raw(MODE_SAMPLE, 10'd523, 10'd1023, 32'hFFFF_FF00);
        queue_raw(MODE_SAMPLE, 10'd523, 10'd1023, 32'h0000_8000);
        clock_ms = 32'h0000_8000;
        run_phase(0, 200, 3000);

        write_all(3'b110, 10'd51, 10'd951, 10'd20, 8'd3, 32'd200, 32'd100, 32'd300);
        run_phase(1, 220, 40);

        write_all(3'b111, 10'd0, 10'd1023, 10'd0, 8'd0, 32'd1, 32'd1, 32'd1);
        run_phase(2, 220, 3);

        write_all(3'b000, 10'd100, 10'd900, 10'd60, 8'd4, 32'd500, 32'd200, 32'd800);
        run_phase(3, 200, 20);

        write_all(3'b010, 10'd1023, 10'd0, 10'd1023, 8'd255,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // long stuck run to reach the highest repeat count
        for (int k = 0; k < 260; k++) queue_raw(MODE_SAMPLE, 10'd0, 10'd300, clock_ms + k);
        run_phase(0, 150, 1000);

        write_all(3'b101, 10'd200, 10'd800, 10'd1023, 8'd1, 32'd1000, 32'hFFFF_FFFF, 32'd1);
        run_phase(1, 220, 100);

        write_all(3'b011, 10'd300, 10'd700, 10'd100, 8'd2, 32'hFFFF_FFFF, 32'd50,
                  32'hFFFF_FFFF);
        run_phase(2, 220, 60);

        write_all(3'($urandom), 10'($urandom_range(200)), 10'($urandom_range(1023, 600)),
                  10'($urandom_range(200)), 8'($urandom_range(8, 1)),
                  $urandom_range(2000, 1), $urandom_range(500, 1),
                  $urandom_range(3000, 1));
        clock_ms = 32'hFFFF_F000;
        run_phase(3, 220, 80);

        repeat (4) @(posedge aclk);
        if (error_count == 0 && expected_alerts.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> pedal_noise_and_drift_monitor.f
hdl/pndm_pkg.sv
hdl/pndm_regs.sv
hdl/pndm_core.sv
hdl/pedal_noise_and_drift_monitor.sv
verif/pedal_noise_and_drift_monitor_test.sv
